// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define WSAP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WSAP_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/wsap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsap_pkg
// Shared types and constants of the windowed average and peak block.
// ----------------------------------------------------------------------------
package wsap_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cmd;

endpackage

// ===== sv/wsap_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsap_front
// Accepts items, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsap_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic signed [15:0]  i_sample,
    output logic                o_q_valid,
    output wsap_pkg::t_cmd      o_q_cmd,
    input  logic                i_q_pop
);
    import wsap_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.op     = t_op'(i_op);
        w_cmd.sample = i_sample;
        unique case (w_cmd.op)
            OP_SAMPLE: w_cmd.sample = i_sample;
            OP_CLEAR:  w_cmd.sample = '0;
            default:   w_cmd.sample = i_sample;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        case ({w_push, i_q_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    `WSAP_ASSERT_RST(a_pop_nonempty, i_clk, i_rst_n, i_q_pop |-> (r_cnt != 2'd0), "pop from empty queue")
    `WSAP_ASSERT_RST(a_cnt_range, i_clk, i_rst_n, r_cnt <= 2'd2, "queue count overflow")
    `WSAP_ASSERT_RST(a_ptr_cnt, i_clk, i_rst_n, (r_cnt == 2'd1) == (r_wp != r_rp), "queue pointers disagree with count")

endmodule

// ===== sv/wsap_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsap_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsap_div #(
    parameter int DW = 20,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int SCW = $clog2(DW);

    logic           r_busy;
    logic           r_done;
    logic [SCW-1:0] r_step;
    logic [VW-1:0]  r_dvs;
    logic [VW-1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic [VW:0]    w_trial;
    logic [VW:0]    w_diff;
    logic           w_fits;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[VW-1:0] : w_trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SCW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/wsap_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsap_back
// Holds the sample ring, walks the filled entries for sum and peak,
// divides by the fill count and registers the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsap_back #(
    parameter int WINDOW_DEPTH = 16,
    parameter int CW           = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  wsap_pkg::t_cmd      i_q_cmd,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_average,
    output logic [14:0]         o_peak,
    output logic [CW-1:0]       o_fill_count
);
    import wsap_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SW = SAMPLE_W + $clog2(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                     r_state;
    logic signed [SAMPLE_W-1:0] r_ring [WINDOW_DEPTH];
    logic [AW-1:0]              r_widx;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              r_iss;
    logic                       r_rd_vld;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SW-1:0]       r_sum;
    logic signed [SAMPLE_W-1:0] r_max;
    logic                       r_neg;
    logic signed [15:0]         r_avg;
    logic [PEAK_W-1:0]          r_peak;
    logic                       r_out_valid;
    logic signed [15:0]         r_out_avg;
    logic [PEAK_W-1:0]          r_out_peak;
    logic [CW-1:0]              r_out_cnt;

    logic          w_issue;
    logic          w_walk_end;
    logic          w_ring_we;
    logic          w_load_out;
    logic [AW-1:0] w_rd_addr;
    logic [SW-1:0] w_mag;
    logic          w_div_done;
    logic [SW-1:0] w_quo;
    logic [15:0]   w_q16;

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign w_ring_we  = o_q_pop && (i_q_cmd.op == OP_SAMPLE);
    assign w_issue    = (r_state == S_WALK) && (r_iss != r_cnt);
    assign w_walk_end = (r_state == S_WALK) && !w_issue && !r_rd_vld;
    assign w_rd_addr  = r_iss[AW-1:0];
    assign w_mag      = $unsigned(r_sum[SW-1] ? -r_sum : r_sum);
    assign w_q16      = w_quo[15:0];
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_widx] <= i_q_cmd.sample;
        end
        r_rd_data <= r_ring[w_rd_addr];
    end

    wsap_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_walk_end),
        .i_dividend (w_mag),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_sum <= '0;
            r_max <= '0;
        end else if (r_rd_vld) begin
            r_sum <= r_sum + SW'(r_rd_data);
            if (r_rd_data > r_max) begin
                r_max <= r_rd_data;
            end
        end
        if (w_walk_end) begin
            r_neg  <= r_sum[SW-1];
            r_peak <= r_max[PEAK_W-1:0];
        end else if (o_q_pop && (i_q_cmd.op == OP_CLEAR)) begin
            r_peak <= '0;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_avg <= $signed(r_neg ? -w_q16 : w_q16);
        end else if (o_q_pop && (i_q_cmd.op == OP_CLEAR)) begin
            r_avg <= '0;
        end
        if (w_load_out) begin
            r_out_avg  <= r_avg;
            r_out_peak <= r_peak;
            r_out_cnt  <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_cnt       <= '0;
            r_iss       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        unique case (i_q_cmd.op)
                            OP_CLEAR: begin
                                r_widx  <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DONE;
                            end
                            OP_SAMPLE: begin
                                r_widx  <= (r_widx == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                            : r_widx + 1'b1;
                                if (r_cnt != CW'(WINDOW_DEPTH)) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                                r_iss   <= '0;
                                r_state <= S_WALK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WALK: begin
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (w_walk_end) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_average    = r_out_avg;
    assign o_peak       = r_out_peak;
    assign o_fill_count = r_out_cnt;

    `WSAP_ASSERT_RST(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(WINDOW_DEPTH), "fill count beyond window")
    `WSAP_ASSERT_RST(a_widx_range, i_clk, i_rst_n, r_widx <= AW'(WINDOW_DEPTH - 1), "write index beyond window")
    `WSAP_ASSERT_RST(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_cnt != '0), "divide by empty window")

endmodule

// ===== sv/windowed_signal_average_peak.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_signal_average_peak
// Moving window average and peak of signed Q8.8 signal-to-noise samples.
// ----------------------------------------------------------------------------
// Each sample item is stored in a ring of the last WINDOW_DEPTH samples and
// returns one item with the mean (truncated toward zero), the maximum floored
// at zero and the fill count; a clear item empties the window and returns
// zeros. For a sample item the ring is read one entry a cycle through its
// single read port, then a bit-serial divider produces one quotient bit a
// cycle. While a result waits in the output register, the back end finishes
// one more item and the two-entry queue at the input takes two more, so up
// to three further items are taken before the input stalls.
module windowed_signal_average_peak #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_op,
    input  logic signed [15:0]                    i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [15:0]                    o_average,
    output logic [14:0]                           o_peak,
    output logic [$clog2(WINDOW_DEPTH + 1)-1:0]   o_fill_count
);
    import wsap_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_q_cmd;

    wsap_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_op      (i_op),
        .i_sample  (i_sample),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .i_q_pop   (w_q_pop)
    );

    wsap_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .CW           (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average),
        .o_peak       (o_peak),
        .o_fill_count (o_fill_count)
    );

endmodule
